// ===== rtl/core/ssw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Safety supervisor package
// Item types, configuration and state records, event and error codes.
// ----------------------------------------------------------------------------
package ssw_pkg;

   // history ring
   localparam int unsigned HIST_DEPTH = 8;
   localparam int unsigned HIST_PTR_W = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

   // event codes
   localparam logic [2:0] FUNC_TICK         = 3'd0;
   localparam logic [2:0] FUNC_EXT_FAULT    = 3'd1;
   localparam logic [2:0] FUNC_CLEAR        = 3'd2;
   localparam logic [2:0] FUNC_COMM_REFRESH = 3'd3;
   localparam logic [2:0] FUNC_TASK_REFRESH = 3'd4;
   localparam logic [2:0] FUNC_STATUS       = 3'd5;
   localparam logic [2:0] FUNC_STOP         = 3'd6;

   // error codes
   localparam logic [3:0] CODE_NONE     = 4'd0;
   localparam logic [3:0] CODE_BATTERY  = 4'd1;
   localparam logic [3:0] CODE_WATCHDOG = 4'd2;

   // register indexes
   localparam logic [1:0] CSR_COMM_TIMEOUT = 2'd0;
   localparam logic [1:0] CSR_WDOG_TIMEOUT = 2'd1;
   localparam logic [1:0] CSR_BATT_WARN    = 2'd2;
   localparam logic [1:0] CSR_BATT_CRIT    = 2'd3;

   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   typedef struct packed {
      logic [2:0]  func;
      logic [15:0] supply_mv;
      logic        battery_present;
      logic [3:0]  fault_code;
      logic [2:0]  history_slot;
   } req_item_type;

   typedef struct packed {
      logic        fault_latched;
      logic [3:0]  last_error_code;
      logic [15:0] fault_total;
      logic        battery_good;
      logic        link_good;
      logic        stop_request;
      logic [3:0]  reported_code;
      logic        clear_accepted;
      logic [3:0]  history_code;
   } rsp_item_type;

   typedef struct packed {
      logic [15:0] comm_timeout_ticks;
      logic [15:0] watchdog_timeout_ticks;
      logic [15:0] warn_level_mv;
      logic [15:0] crit_level_mv;
   } cfg_type;

   typedef struct packed {
      logic                  fault_flag;
      logic [3:0]            latched_code;
      logic [15:0]           fault_counter;
      logic [15:0]           link_counter;
      logic [15:0]           task_counter;
      logic                  battery_flag;
      logic                  link_flag;
      logic [HIST_PTR_W-1:0] hist_ptr;
   } sup_state_type;

   // per-event outcome beside the state update
   typedef struct packed {
      logic                  stop_request;
      logic [3:0]            reported_code;
      logic                  clear_accepted;
      logic                  hist_we;
      logic [HIST_PTR_W-1:0] hist_addr;
      logic [3:0]            hist_code;
   } evt_result_type;

   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      return (v == COUNT_MAX) ? v : v + 16'd1;
   endfunction

endpackage

// ===== rtl/core/ssw_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Safety supervisor event evaluation
// Applies one event to the supervisor state: next state and event outcome.
// ----------------------------------------------------------------------------
module ssw_eval (
   input  ssw_pkg::cfg_type        cfg,
   input  ssw_pkg::sup_state_type  cur,
   input  ssw_pkg::req_item_type   item,
   output ssw_pkg::sup_state_type  nxt,
   output ssw_pkg::evt_result_type evt
);
   import ssw_pkg::*;

   logic       raise;
   logic [3:0] raise_code;

   always_comb begin
      nxt        = cur;
      raise      = 1'b0;
      raise_code = CODE_NONE;
      evt        = '0;

      unique case (item.func)
         FUNC_TICK: begin
            if (item.battery_present && (item.supply_mv < cfg.crit_level_mv)) begin
               raise      = 1'b1;
               raise_code = CODE_BATTERY;
            end else begin
               if (item.battery_present) begin
                  nxt.battery_flag = (item.supply_mv >= cfg.warn_level_mv);
               end
               if (cur.link_counter >= cfg.comm_timeout_ticks) begin
                  nxt.link_flag = 1'b0;
               end
               if (cur.task_counter >= cfg.watchdog_timeout_ticks) begin
                  raise      = 1'b1;
                  raise_code = CODE_WATCHDOG;
               end else begin
                  nxt.link_counter = sat_inc(cur.link_counter);
                  nxt.task_counter = sat_inc(cur.task_counter);
               end
            end
         end
         FUNC_EXT_FAULT: begin
            raise      = 1'b1;
            raise_code = item.fault_code;
         end
         FUNC_CLEAR: begin
            if (cur.battery_flag && cur.link_flag) begin
               nxt.fault_flag     = 1'b0;
               nxt.latched_code   = CODE_NONE;
               nxt.task_counter   = '0;
               evt.clear_accepted = 1'b1;
            end
         end
         FUNC_COMM_REFRESH: begin
            nxt.link_counter = '0;
            nxt.link_flag    = 1'b1;
         end
         FUNC_TASK_REFRESH: begin
            nxt.task_counter = '0;
         end
         FUNC_STOP: begin
            evt.stop_request = 1'b1;
         end
         default: begin
            // status read and spare code: no effect
         end
      endcase

      // a fault only latches when none is active
      if (raise) begin
         evt.stop_request  = 1'b1;
         evt.reported_code = raise_code;
         if (!cur.fault_flag) begin
            nxt.fault_flag    = 1'b1;
            nxt.latched_code  = raise_code;
            nxt.fault_counter = sat_inc(cur.fault_counter);
            evt.hist_we       = 1'b1;
            evt.hist_addr     = cur.hist_ptr;
            evt.hist_code     = raise_code;
            nxt.hist_ptr      = (cur.hist_ptr == HIST_PTR_W'(HIST_DEPTH - 1)) ?
                                '0 : cur.hist_ptr + 1'b1;
         end
      end
   end

endmodule

// ===== rtl/core/safety_supervisor_watchdog.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Safety supervisor with watchdog
// Battery, link and task supervision with fault latch and fault history ring.
// ----------------------------------------------------------------------------
// One event item in, one status item out. An accepted item sits in the input
// register, is evaluated there against the supervisor state in a single pass
// of compares and saturating increments, and the status is written to the
// result register once that register is free or emptying. rsp_valid comes
// from the result register; throughput is one item per cycle while rsp_ready
// holds, set by the state update loop. The input stage keeps taking items
// while a result waits, until both stages are full. Thresholds and timeouts
// come from four registers on the csr_ port; the user must write them only
// while the block is idle, which the block itself does not enforce. The
// status fields show the state after the event; history_code reads the ring
// entry chosen by history_slot, including an entry written by the same item.
// ----------------------------------------------------------------------------
module safety_supervisor_watchdog (
   input  logic                  clock,
   input  logic                  reset,
   // event items
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ssw_pkg::req_item_type req_item,
   // status items
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ssw_pkg::rsp_item_type rsp_item,
   // configuration writes
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_wdata
);
   import ssw_pkg::*;

   // configuration
   cfg_type        cfg_ff;

   // input stage
   logic           in_valid_ff;
   req_item_type   in_item_ff;

   // supervisor state and fault history
   sup_state_type  state_ff;
   sup_state_type  state_in;
   evt_result_type evt;
   logic [3:0]     hist_ff [HIST_DEPTH];

   // result stage
   logic           rsp_valid_ff;
   rsp_item_type   rsp_item_ff;
   rsp_item_type   rsp_item_in;

   logic           advance;
   logic           slot_in_range;
   logic [HIST_PTR_W-1:0] slot_idx;

   // the evaluation stage moves when the result register is free or emptying
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.comm_timeout_ticks     <= 16'd500;
         cfg_ff.watchdog_timeout_ticks <= 16'd1000;
         cfg_ff.warn_level_mv          <= 16'd3300;
         cfg_ff.crit_level_mv          <= 16'd3000;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_COMM_TIMEOUT: cfg_ff.comm_timeout_ticks     <= csr_wdata;
            CSR_WDOG_TIMEOUT: cfg_ff.watchdog_timeout_ticks <= csr_wdata;
            CSR_BATT_WARN:    cfg_ff.warn_level_mv          <= csr_wdata;
            CSR_BATT_CRIT:    cfg_ff.crit_level_mv          <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_item;
      end
   end

   // event evaluation
   ssw_eval u_eval (
      .cfg  (cfg_ff),
      .cur  (state_ff),
      .item (in_item_ff),
      .nxt  (state_in),
      .evt  (evt)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{fault_flag:    1'b0,
                       latched_code:  CODE_NONE,
                       fault_counter: '0,
                       link_counter:  '0,
                       task_counter:  '0,
                       battery_flag:  1'b1,
                       link_flag:     1'b1,
                       hist_ptr:      '0};
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // history ring, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HIST_DEPTH; i++) begin
            hist_ff[i] <= CODE_NONE;
         end
      end else if (advance && evt.hist_we) begin
         hist_ff[evt.hist_addr] <= evt.hist_code;
      end
   end

   // readback of the chosen slot; an entry written by this item is passed on
   assign slot_in_range = (32'(in_item_ff.history_slot) < HIST_DEPTH);
   assign slot_idx      = HIST_PTR_W'(in_item_ff.history_slot);

   always_comb begin
      rsp_item_in.fault_latched   = state_in.fault_flag;
      rsp_item_in.last_error_code = state_in.latched_code;
      rsp_item_in.fault_total     = state_in.fault_counter;
      rsp_item_in.battery_good    = state_in.battery_flag;
      rsp_item_in.link_good       = state_in.link_flag;
      rsp_item_in.stop_request    = evt.stop_request;
      rsp_item_in.reported_code   = evt.reported_code;
      rsp_item_in.clear_accepted  = evt.clear_accepted;
      if (!slot_in_range) begin
         rsp_item_in.history_code = CODE_NONE;
      end else if (evt.hist_we && (evt.hist_addr == slot_idx)) begin
         rsp_item_in.history_code = evt.hist_code;
      end else begin
         rsp_item_in.history_code = hist_ff[slot_idx];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

`ifndef NO_ASSERTIONS
   // fault total never goes back outside reset
   a_fault_total_monotonic: assert property (@(posedge clock) disable iff (reset)
      !reset |=> state_ff.fault_counter >= $past(state_ff.fault_counter))
      else $error("fault counter decreased");

   // a newly latched fault counts up by one unless saturated
   a_latch_counts: assert property (@(posedge clock) disable iff (reset)
      (advance && evt.hist_we && (state_ff.fault_counter != COUNT_MAX)) |=>
      (state_ff.fault_counter == $past(state_ff.fault_counter) + 16'd1))
      else $error("latched fault not counted");

   // any reported fault demands a stop
   a_report_stops: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_item_ff.reported_code != CODE_NONE)) |->
      rsp_item_ff.stop_request)
      else $error("reported fault without stop request");

   // a granted clear leaves no latched fault
   a_clear_drops_fault: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.clear_accepted) |->
      (!rsp_item_ff.fault_latched && (rsp_item_ff.last_error_code == CODE_NONE)))
      else $error("clear granted but fault still latched");
`endif

endmodule
